>>> sv/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, suspended during reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))

`endif

>>> sv/alpe_pkg.sv
// Shared types, constants and helpers of the LED pulse encoder.
package alpe_pkg;

  localparam int TimerBits = 16;
  localparam logic [31:0] TimerMax32 = 32'((64'd1 << TimerBits) - 64'd1);

  typedef logic [TimerBits-1:0] timer_t;

  // Reset values of the timing registers.
  localparam logic [7:0]  OneHighReset  = 8'(64 - 16);
  localparam logic [7:0]  OneLowReset   = 8'd11;
  localparam logic [7:0]  ZeroHighReset = 8'(28 - 16);
  localparam logic [7:0]  ZeroLowReset  = 8'd47;
  localparam logic [15:0] ResetLowReset = 16'd8000;

  // Configuration register indexes.
  localparam logic [2:0] CfgOneHigh  = 3'd0;
  localparam logic [2:0] CfgOneLow   = 3'd1;
  localparam logic [2:0] CfgZeroHigh = 3'd2;
  localparam logic [2:0] CfgZeroLow  = 3'd3;
  localparam logic [2:0] CfgResetLow = 3'd4;

  localparam logic ActTick = 1'b0;
  localparam logic ActPush = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic ready_res;
    logic frame_done;
    logic push_dropped;
  } out_item_t;

  // Classified command handed from the front queue to the engine.
  typedef struct packed {
    logic       is_push;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  // A time of zero counts as one tick; a time beyond the timer saturates.
  function automatic timer_t load_ticks(logic [15:0] v);
    logic [31:0] w;
    timer_t      r;
    w = {16'b0, v};
    if (w == 32'd0) begin
      w = 32'd1;
    end
    if (w > TimerMax32) begin
      r = '1;
    end else begin
      r = timer_t'(w);
    end
    return r;
  endfunction

endpackage

>>> sv/alpe_front.sv
// Front end: accepts input items, classifies them and queues them for the engine.
`include "assert_macros.svh"

module alpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  alpe_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output alpe_pkg::cmd_t    cmd_o
);

  alpe_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_en, rd_en;
  alpe_pkg::cmd_t cmd_in;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.is_push   = (in_item_i.action == alpe_pkg::ActPush);
    cmd_in.data_byte = in_item_i.data_byte;
    cmd_in.last_byte = in_item_i.last_byte;
  end

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  // A full queue that is not drained stays full.
  `ASSERT_CLK(a_front_full_holds, (full && !cmd_pop_i) |=> full)

endmodule

>>> sv/alpe_engine.sv
// Back end: bit timing state machine that turns each command into one result.
`include "assert_macros.svh"

module alpe_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                cmd_valid_i,
  input  alpe_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output alpe_pkg::out_item_t res_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhHigh,
    PhLow,
    PhReset
  } phase_e;

  logic [7:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
  logic [15:0] reset_low_q;

  phase_e            phase_q, phase_d;
  alpe_pkg::timer_t  timer_q, timer_d;
  logic [7:0]        shift_q, shift_d;
  logic [3:0]        bits_q, bits_d;
  logic              ending_q, ending_d;
  logic [7:0]        pend_byte_q, pend_byte_d;
  logic              pend_valid_q, pend_valid_d;
  logic              pend_last_q, pend_last_d;
  alpe_pkg::out_item_t res_d;
  logic              fire;

  assign fire        = cmd_valid_i && res_ready_i;
  assign cmd_pop_o   = fire;
  assign res_valid_o = fire;
  assign res_o       = res_d;

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    shift_d      = shift_q;
    bits_d       = bits_q;
    ending_d     = ending_q;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    pend_last_d  = pend_last_q;
    res_d        = '0;

    if (cmd_i.is_push) begin
      if (pend_valid_q) begin
        res_d.push_dropped = 1'b1;
      end else begin
        pend_byte_d  = cmd_i.data_byte;
        pend_last_d  = cmd_i.last_byte;
        pend_valid_d = 1'b1;
      end
      res_d.line_level = (phase_q == PhHigh);
    end else begin
      // An idle encoder with a waiting byte starts it on this tick.
      if (phase_q == PhIdle && pend_valid_q) begin
        shift_d      = pend_byte_q;
        ending_d     = pend_last_q;
        bits_d       = 4'd8;
        pend_valid_d = 1'b0;
        pend_last_d  = 1'b0;
        phase_d      = PhHigh;
        timer_d      = alpe_pkg::load_ticks(
                         {8'b0, pend_byte_q[7] ? one_high_q : zero_high_q});
      end
      res_d.line_level = (phase_d == PhHigh);
      if (phase_d != PhIdle) begin
        if (timer_d != '0) begin
          timer_d = timer_d - alpe_pkg::timer_t'(1);
        end
        if (timer_d == '0) begin
          case (phase_d)
            PhHigh: begin
              phase_d = PhLow;
              timer_d = alpe_pkg::load_ticks(
                          {8'b0, shift_d[7] ? one_low_q : zero_low_q});
            end
            PhLow: begin
              shift_d = {shift_d[6:0], 1'b0};
              if (bits_d != 4'd0) begin
                bits_d = bits_d - 4'd1;
              end
              if (bits_d != 4'd0) begin
                phase_d = PhHigh;
                timer_d = alpe_pkg::load_ticks(
                            {8'b0, shift_d[7] ? one_high_q : zero_high_q});
              end else if (ending_d) begin
                phase_d = PhReset;
                timer_d = alpe_pkg::load_ticks(reset_low_q);
              end else if (pend_valid_d) begin
                // Back-to-back bytes follow with no idle gap.
                shift_d      = pend_byte_d;
                ending_d     = pend_last_d;
                bits_d       = 4'd8;
                pend_valid_d = 1'b0;
                pend_last_d  = 1'b0;
                phase_d      = PhHigh;
                timer_d      = alpe_pkg::load_ticks(
                                 {8'b0, pend_byte_d[7] ? one_high_q : zero_high_q});
              end else begin
                phase_d = PhIdle;
              end
            end
            PhReset: begin
              res_d.frame_done = 1'b1;
              ending_d         = 1'b0;
              phase_d          = PhIdle;
            end
            default: begin
              phase_d = PhIdle;
            end
          endcase
        end
      end
    end
    res_d.ready_res = !pend_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      timer_q      <= '0;
      shift_q      <= 8'd0;
      bits_q       <= 4'd0;
      ending_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_last_q  <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      shift_q      <= shift_d;
      bits_q       <= bits_d;
      ending_q     <= ending_d;
      pend_valid_q <= pend_valid_d;
      pend_last_q  <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_byte_q <= pend_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= alpe_pkg::OneHighReset;
      one_low_q   <= alpe_pkg::OneLowReset;
      zero_high_q <= alpe_pkg::ZeroHighReset;
      zero_low_q  <= alpe_pkg::ZeroLowReset;
      reset_low_q <= alpe_pkg::ResetLowReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        alpe_pkg::CfgOneHigh:  one_high_q  <= cfg_data_i[7:0];
        alpe_pkg::CfgOneLow:   one_low_q   <= cfg_data_i[7:0];
        alpe_pkg::CfgZeroHigh: zero_high_q <= cfg_data_i[7:0];
        alpe_pkg::CfgZeroLow:  zero_low_q  <= cfg_data_i[7:0];
        alpe_pkg::CfgResetLow: reset_low_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A running phase always has time left, and a bit phase has bits left.
  `ASSERT_NEVER(a_eng_timer_live, phase_q != PhIdle && timer_q == '0)
  `ASSERT_NEVER(a_eng_bits_live, (phase_q == PhHigh || phase_q == PhLow) && bits_q == 4'd0)

endmodule

>>> sv/alpe_res_queue.sv
// Result queue between the engine and the output side.
`include "assert_macros.svh"

module alpe_res_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  alpe_pkg::out_item_t res_i,
  output logic                res_ready_o,
  output logic                empty,
  input  logic                pop,
  output alpe_pkg::out_item_t out_item_o
);

  alpe_pkg::out_item_t entry_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty       = (cnt_q == 2'd0);
  assign out_item_o  = entry_q[rd_ptr_q];
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

  // Fill level tracks the pointer distance.
  `ASSERT_CLK(a_res_level, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))

endmodule

>>> sv/addressable_led_pulse_encoder.sv
// Top level of the addressable LED pulse-width serial encoder.
`include "assert_macros.svh"

// Each tick item advances the bit timing by one and returns the line level;
// each push item offers a pixel byte to the one-byte pending slot. One item
// is taken per clock when neither side stalls: items pass through a
// two-entry command queue, a timing engine that applies one item per clock
// while the result queue has room, and a two-entry result queue that
// registers each result. Timing registers are written through the always
// ready configuration channel; the user must write them only while the
// block is idle, since the block itself does not enforce this.
module addressable_led_pulse_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  alpe_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output alpe_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic                cmd_valid, cmd_pop;
  alpe_pkg::cmd_t      cmd;
  logic                res_valid, res_ready;
  alpe_pkg::out_item_t res;

  assign cfg_ready_o = 1'b1;

  alpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  alpe_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  alpe_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule
